[src/cst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the command slot tracker.
package cst_pkg;

	localparam int CFG_W        = 6;
	localparam int TAG_W        = 32;
	localparam int TFS_W        = 16;
	localparam int SLOT_W       = 5;
	localparam int ERR_BIT      = 0;
	localparam int ERR_QUAL_BIT = 10;

	localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

	localparam logic KIND_ISSUE = 1'b0;
	localparam logic KIND_INTR  = 1'b1;

	typedef enum logic [1:0] {
		RK_ISSUED  = 2'd0,
		RK_DONE    = 2'd1,
		RK_BUSY    = 2'd2,
		RK_DEV_ERR = 2'd3
	} result_kind_t;

	typedef struct packed {
		logic             intr;
		logic             notify;
		logic             err;
		logic [TAG_W-1:0] data;
	} req_t;

endpackage

[src/cst_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/cst_front.sv]
`timescale 1ns / 1ps
// Front end: accepts requests and classifies them for the queue.
module cst_front (
	input  logic                        start,
	input  logic                        full,
	input  logic                        kind,
	input  logic [cst_pkg::TAG_W-1:0]   user_tag,
	input  logic                        notify,
	input  logic [cst_pkg::TAG_W-1:0]   issued_mask,
	input  logic [cst_pkg::TFS_W-1:0]   task_file_status,
	output logic                        push,
	output cst_pkg::req_t               req
);
	import cst_pkg::*;

	always_comb begin
		req.intr   = (kind == KIND_INTR);
		req.notify = notify;
		req.err    = task_file_status[ERR_BIT] & ~task_file_status[ERR_QUAL_BIT];
		req.data   = (kind == KIND_INTR) ? issued_mask : user_tag;
	end

	assign push = start & ~full;

endmodule

[src/cst_queue.sv]
`timescale 1ns / 1ps
// Two-entry request queue between front end and back end.
module cst_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cst_pkg::req_t push_req,
	output logic          full,
	input  logic          pop,
	output cst_pkg::req_t pop_req,
	output logic          empty
);
	import cst_pkg::*;

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	req_t          entry_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_req = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_req;
		end
	end

endmodule

[src/cst_back.sv]
`timescale 1ns / 1ps
// Back end: slot allocation, completion scan and result generation.
module cst_back #(
	parameter int SLOTS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  cst_pkg::req_t               req,
	output logic                        pop,
	input  logic [cst_pkg::CFG_W-1:0]   slot_count,
	output logic                        result_valid,
	output logic [1:0]                  result_kind,
	output logic [cst_pkg::SLOT_W-1:0]  slot,
	output logic [cst_pkg::TAG_W-1:0]   done_tag,
	output logic                        last
);
	import cst_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_ERR  = 3'b100
	} state_t;

	state_t           state_q;
	logic [SLOTS-1:0] busy_q;
	logic [SLOTS-1:0] notify_q;
	logic [SLOTS-1:0] pend_q;
	logic [SW-1:0]    next_q;
	logic             err_q;
	logic             cmp_valid_s1;
	logic [SW-1:0]    cmp_slot_s1;
	logic             cmp_last_s1;
	logic             res_valid_q;
	result_kind_t     res_kind_q;
	logic [SW-1:0]    res_slot_q;

	logic [CFG_W-1:0] eff_cnt;
	logic [CFG_W-1:0] slot_inc;
	logic [SW-1:0]    iss_slot;
	logic [SW-1:0]    iss_next;
	logic             iss_hit;
	logic [SLOTS-1:0] done_m;
	logic [SLOTS-1:0] rep_m;
	logic [SLOTS-1:0] pend_rest;
	logic [SW-1:0]    low_slot;
	logic [TAG_W-1:0] ram_rdata;
	logic             ram_we;

	always_comb begin
		priority if (slot_count == '0) begin
			eff_cnt = CFG_W'(1);
		end else if (slot_count > CFG_W'(SLOTS)) begin
			eff_cnt = CFG_W'(SLOTS);
		end else begin
			eff_cnt = slot_count;
		end
	end

	assign iss_slot  = (CFG_W'(next_q) < eff_cnt) ? next_q : '0;
	assign iss_hit   = busy_q[iss_slot];
	assign slot_inc  = CFG_W'(iss_slot) + CFG_W'(1);
	assign iss_next  = (slot_inc == eff_cnt) ? '0 : SW'(slot_inc);

	assign done_m    = busy_q & ~req.data[SLOTS-1:0];
	assign rep_m     = done_m & notify_q;
	assign pend_rest = pend_q & (pend_q - SLOTS'(1));

	always_comb begin
		low_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				low_slot = SW'(i);
			end
		end
	end

	assign pop    = (state_q == ST_IDLE) && req_valid;
	assign ram_we = pop && !req.intr && !iss_hit;

	cst_ram #(
		.WIDTH(TAG_W),
		.DEPTH(SLOTS),
		.AW   (SW)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(iss_slot),
		.wdata(req.data),
		.re   (state_q == ST_SCAN),
		.raddr(low_slot),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy_q       <= '0;
			next_q       <= '0;
			pend_q       <= '0;
			err_q        <= 1'b0;
			cmp_valid_s1 <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q  <= 1'b0;
			cmp_valid_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (!req.intr) begin
							res_valid_q <= 1'b1;
							if (!iss_hit) begin
								busy_q[iss_slot] <= 1'b1;
								next_q           <= iss_next;
							end
						end else begin
							busy_q <= req.err ? '0 : (busy_q & ~done_m);
							pend_q <= rep_m;
							err_q  <= req.err;
							if (rep_m != '0) begin
								state_q <= ST_SCAN;
							end else if (req.err) begin
								res_valid_q <= 1'b1;
							end
						end
					end
				end
				ST_SCAN: begin
					pend_q       <= pend_rest;
					cmp_valid_s1 <= 1'b1;
					if (pend_rest == '0) begin
						state_q <= err_q ? ST_ERR : ST_IDLE;
					end
				end
				ST_ERR: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !req.intr) begin
			res_kind_q <= iss_hit ? RK_BUSY : RK_ISSUED;
			res_slot_q <= iss_slot;
			if (!iss_hit) begin
				notify_q[iss_slot] <= req.notify;
			end
		end else if ((pop && req.intr) || (state_q == ST_ERR)) begin
			res_kind_q <= RK_DEV_ERR;
			res_slot_q <= '0;
		end
		cmp_slot_s1 <= low_slot;
		cmp_last_s1 <= (pend_rest == '0) && !err_q;
	end

	assign result_valid = cmp_valid_s1 | res_valid_q;
	assign result_kind  = cmp_valid_s1 ? RK_DONE : res_kind_q;
	assign slot         = SLOT_W'(cmp_valid_s1 ? cmp_slot_s1 : res_slot_q);
	assign done_tag     = cmp_valid_s1 ? ram_rdata : '0;
	assign last         = cmp_valid_s1 ? cmp_last_s1 : 1'b1;

`ifndef SYNTHESIS
	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmp_valid_s1 && res_valid_q))
		else $error("completion and request result collide");
	a_pend_freed: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & busy_q) == '0)
		else $error("pending completion still marked busy");
	a_scan_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (pend_q != '0))
		else $error("scan with no pending completion");
	a_cmp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid_s1 |-> $past(state_q == ST_SCAN))
		else $error("completion result without scan");
`endif

endmodule

[src/command_slot_tracker.sv]
`timescale 1ns / 1ps
// Top level of the command slot tracker.
//
// A request is taken when start is high and busy is low; busy rises only while
// the two-entry request queue is full. Results come out on result_valid for one
// cycle each and cannot be held off. An issue request gives its single result
// from a register in the back end once it is popped from the queue, and leaves
// the back end idle. An interrupt with reported completions moves the back end
// from idle into its scan state, then into its error state when the status
// carries a device error: the slot tag RAM has one read port, so completions
// leave one per cycle in ascending slot order, the error result after them.
// Silent completions give no result. No clearing pass after reset.
module command_slot_tracker #(
	parameter int SLOTS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        kind,
	input  logic [cst_pkg::TAG_W-1:0]   user_tag,
	input  logic                        notify,
	input  logic [cst_pkg::TAG_W-1:0]   issued_mask,
	input  logic [cst_pkg::TFS_W-1:0]   task_file_status,
	input  logic                        cfg_we,
	input  logic [cst_pkg::CFG_W-1:0]   cfg_wdata,
	output logic                        result_valid,
	output logic [1:0]                  result_kind,
	output logic [cst_pkg::SLOT_W-1:0]  slot,
	output logic [cst_pkg::TAG_W-1:0]   done_tag,
	output logic                        last
);
	import cst_pkg::*;

	logic             full;
	logic             empty;
	logic             push;
	logic             pop;
	req_t             push_req;
	req_t             pop_req;
	logic [CFG_W-1:0] slot_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= CFG_RESET;
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
		end
	end

	assign busy = full;

	cst_front u_front (
		.start           (start),
		.full            (full),
		.kind            (kind),
		.user_tag        (user_tag),
		.notify          (notify),
		.issued_mask     (issued_mask),
		.task_file_status(task_file_status),
		.push            (push),
		.req             (push_req)
	);

	cst_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_req(push_req),
		.full    (full),
		.pop     (pop),
		.pop_req (pop_req),
		.empty   (empty)
	);

	cst_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (!empty),
		.req         (pop_req),
		.pop         (pop),
		.slot_count  (slot_count_q),
		.result_valid(result_valid),
		.result_kind (result_kind),
		.slot        (slot),
		.done_tag    (done_tag),
		.last        (last)
	);

endmodule
